@@ design/gsi_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// gsi_pkg
// Shared types and constants of the gain schedule interpolator.
// ============================================================================
package gsi_pkg;

    localparam int TABLE_ROWS = 16;
    localparam int ROW_W      = $clog2(TABLE_ROWS);
    localparam int NUM_VALS   = 6;   // four gains, eq angle, eq drive
    localparam int VAL_W      = 32;
    localparam int FRAC_W     = 16;
    localparam int T_W        = FRAC_W + 1;  // t spans 0..65536
    localparam int VI_W       = $clog2(NUM_VALS);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    typedef logic [NUM_VALS-1:0][VAL_W-1:0] t_vals;

    typedef struct packed {
        logic              is_eval;
        logic              row_ok;
        logic [ROW_W-1:0]  row;
        logic [VAL_W-1:0]  angle;
        logic [VAL_W-1:0]  bp;
        t_vals             vals;
    } t_cmd;

endpackage

@@ design/gain_schedule_interpolator.sv @@
`timescale 1ns / 1ps
// ============================================================================
// gain_schedule_interpolator
// Piecewise-linear gain schedule lookup over a 16-row Q16.16 table.
// ============================================================================
// A write item passes through the queue into the table and gives no result.
// An evaluate is checked first against the first row, then the last, and
// if clamped returns that row as written; an interpolated one is paced by
// the serial breakpoint scan (one read per row), the 17-step fraction
// divider and six multiply/add passes through one shared multiplier.
// Items queued ahead add their time.
// The engine handles one evaluate at a time; a two-entry queue takes items while
// the engine works. The result strobe lasts one cycle, nothing stalls it.
// Reset (synchronous, active low) clears control only; table contents are
// undefined until written.
module gain_schedule_interpolator
    import gsi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_op,
    input  logic [3:0]  i_row_index,
    input  logic [31:0] i_hip_angle,
    input  logic [31:0] i_breakpoint_in,
    input  logic [31:0] i_gain_in_0,
    input  logic [31:0] i_gain_in_1,
    input  logic [31:0] i_gain_in_2,
    input  logic [31:0] i_gain_in_3,
    input  logic [31:0] i_eq_angle_in,
    input  logic [31:0] i_eq_drive_in,
    output logic        o_strobe,
    output logic        o_valid_out,
    output logic [31:0] o_gain_out_0,
    output logic [31:0] o_gain_out_1,
    output logic [31:0] o_gain_out_2,
    output logic [31:0] o_gain_out_3,
    output logic [31:0] o_eq_angle_out,
    output logic [31:0] o_eq_drive_out
);

    t_vals in_vals, out_vals;
    t_cmd  cmd;
    logic  avail, full, pop, push;

    // a transfer happens when start meets a free queue slot
    assign push = start && !full;
    assign busy = full;

    assign in_vals[0] = i_gain_in_0;
    assign in_vals[1] = i_gain_in_1;
    assign in_vals[2] = i_gain_in_2;
    assign in_vals[3] = i_gain_in_3;
    assign in_vals[4] = i_eq_angle_in;
    assign in_vals[5] = i_eq_drive_in;

    // front: decode and queue
    gsi_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_op        (i_op),
        .i_row_index (i_row_index),
        .i_angle     (i_hip_angle),
        .i_bp        (i_breakpoint_in),
        .i_vals      (in_vals),
        .i_pop       (pop),
        .o_cmd       (cmd),
        .o_avail     (avail),
        .o_full      (full)
    );

    // back: table, scan, divide, interpolate
    gsi_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_avail  (avail),
        .i_cmd    (cmd),
        .o_pop    (pop),
        .o_strobe (o_strobe),
        .o_valid  (o_valid_out),
        .o_vals   (out_vals)
    );

    assign o_gain_out_0   = out_vals[0];
    assign o_gain_out_1   = out_vals[1];
    assign o_gain_out_2   = out_vals[2];
    assign o_gain_out_3   = out_vals[3];
    assign o_eq_angle_out = out_vals[4];
    assign o_eq_drive_out = out_vals[5];

endmodule

@@ design/gsi_front.sv @@
`timescale 1ns / 1ps
// ============================================================================
// gsi_front
// Accepts items, decodes them and holds them in a two-entry command queue.
// ============================================================================
module gsi_front
    import gsi_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic             i_op,
    input  logic [3:0]       i_row_index,
    input  logic [VAL_W-1:0] i_angle,
    input  logic [VAL_W-1:0] i_bp,
    input  t_vals            i_vals,
    input  logic             i_pop,
    output t_cmd             o_cmd,
    output logic             o_avail,
    output logic             o_full
);

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       n_cmd;

    always_comb begin
        n_cmd         = '0;
        n_cmd.is_eval = (i_op == OP_EVAL);
        n_cmd.row_ok  = (int'(i_row_index) < TABLE_ROWS);
        n_cmd.row     = ROW_W'(i_row_index);
        n_cmd.angle   = i_angle;
        n_cmd.bp      = i_bp;
        n_cmd.vals    = i_vals;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_cmd   = r_q[r_rp];
    assign o_avail = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_cnt != 2'd0) else $error("pop from empty queue");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> r_cnt != 2'd2) else $error("push into full queue");

endmodule

@@ design/gsi_back.sv @@
`timescale 1ns / 1ps
// ============================================================================
// gsi_back
// Table storage, breakpoint scan, fraction divider and serial interpolation.
// ============================================================================
module gsi_back
    import gsi_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_avail,
    input  t_cmd  i_cmd,
    output logic  o_pop,
    output logic  o_strobe,
    output logic  o_valid,
    output t_vals o_vals
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CHK0 = 4'd1;
    localparam logic [3:0] S_CHKL = 4'd2;
    localparam logic [3:0] S_SCAN = 4'd3;
    localparam logic [3:0] S_DIV  = 4'd4;
    localparam logic [3:0] S_RDA  = 4'd5;
    localparam logic [3:0] S_RDB  = 4'd6;
    localparam logic [3:0] S_RDC  = 4'd7;
    localparam logic [3:0] S_MUL  = 4'd8;
    localparam logic [3:0] S_ADD  = 4'd9;
    localparam logic [3:0] S_ROW  = 4'd10;

    localparam logic [ROW_W-1:0] LAST = ROW_W'(TABLE_ROWS - 1);
    localparam logic [4:0]       DIV_LAST = 5'(FRAC_W);

    // storage, no reset (contents undefined until written)
    logic [VAL_W-1:0] r_bp_mem  [TABLE_ROWS];
    t_vals            r_row_mem [TABLE_ROWS];
    logic [VAL_W-1:0] r_bp_rd;
    t_vals            r_row_rd;
    logic [ROW_W-1:0] bp_addr, row_addr;

    logic [3:0]              r_state;
    logic signed [VAL_W-1:0] r_angle, r_prev;
    logic [ROW_W-1:0]        r_k, r_seg;
    logic [VAL_W:0]          r_den, r_rem;
    logic [4:0]              r_dcnt;
    logic [T_W-1:0]          r_t;
    t_vals                   r_row0, r_row1;
    logic [VI_W-1:0]         r_vi;
    logic signed [50:0]      r_prod;
    logic                    r_strobe, r_valid;
    t_vals                   r_out;
    logic                    n_strobe;

    logic signed [VAL_W-1:0] bp_s;
    logic                    seg_hit;
    logic [VAL_W+1:0]        trial;
    logic                    ge;
    logic signed [VAL_W:0]   dlt;
    logic signed [34:0]      frac_q;
    logic signed [35:0]      sum;
    logic [VAL_W-1:0]        sat;

    assign bp_s    = $signed(r_bp_rd);
    assign seg_hit = (r_prev <= r_angle) && (r_angle <= bp_s);
    assign o_pop   = (r_state == S_IDLE) && i_avail;

    // result strobe: clamped row, no segment, or last value written
    assign n_strobe = (r_state == S_ROW)
                   || (r_state == S_SCAN && !seg_hit && r_k == LAST)
                   || (r_state == S_ADD && r_vi == VI_W'(NUM_VALS - 1));

    always_comb begin
        unique case (r_state)
            S_CHK0:  bp_addr = LAST;
            S_CHKL:  bp_addr = ROW_W'(1);
            S_SCAN:  bp_addr = r_k + ROW_W'(1);
            default: bp_addr = '0;
        endcase
        unique case (r_state)
            S_CHK0:  row_addr = '0;
            S_CHKL:  row_addr = LAST;
            S_RDB:   row_addr = r_seg + ROW_W'(1);
            default: row_addr = r_seg;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && !i_cmd.is_eval && i_cmd.row_ok) begin
            r_bp_mem[i_cmd.row]  <= i_cmd.bp;
            r_row_mem[i_cmd.row] <= i_cmd.vals;
        end
        r_bp_rd  <= r_bp_mem[bp_addr];
        r_row_rd <= r_row_mem[row_addr];
    end

    // divider step and interpolation datapath
    always_comb begin
        trial  = (r_dcnt == 5'd0) ? {1'b0, r_rem} : {r_rem, 1'b0};
        ge     = (trial >= {1'b0, r_den});
        dlt    = $signed({r_row1[r_vi][VAL_W-1], r_row1[r_vi]})
               - $signed({r_row0[r_vi][VAL_W-1], r_row0[r_vi]});
        frac_q = r_prod[50:FRAC_W];
        sum    = 36'(frac_q) + 36'($signed(r_row0[r_vi]));
        if (sum > 36'sd2147483647)       sat = 32'h7FFF_FFFF;
        else if (sum < -36'sd2147483648) sat = 32'h8000_0000;
        else                             sat = sum[VAL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: r_angle <= $signed(i_cmd.angle);
            S_CHK0: r_prev  <= bp_s;
            S_CHKL: r_k     <= ROW_W'(1);
            S_SCAN: begin
                r_prev <= bp_s;
                r_k    <= r_k + ROW_W'(1);
                r_seg  <= r_k - ROW_W'(1);
                r_den  <= (VAL_W+1)'({bp_s[VAL_W-1], bp_s} - {r_prev[VAL_W-1], r_prev});
                r_rem  <= (VAL_W+1)'({r_angle[VAL_W-1], r_angle}
                                     - {r_prev[VAL_W-1], r_prev});
                r_dcnt <= 5'd0;
                r_t    <= '0;
            end
            S_DIV: begin
                r_rem  <= ge ? (VAL_W+1)'(trial - {1'b0, r_den}) : (VAL_W+1)'(trial);
                r_t    <= (r_den == '0) ? '0 : {r_t[T_W-2:0], ge};
                r_dcnt <= r_dcnt + 5'd1;
            end
            S_RDB: r_row0 <= r_row_rd;
            S_RDC: begin
                r_row1 <= r_row_rd;
                r_vi   <= '0;
            end
            S_MUL: r_prod <= dlt * $signed({1'b0, r_t});
            S_ADD: begin
                r_out[r_vi] <= sat;
                r_vi        <= r_vi + VI_W'(1);
            end
            S_ROW: r_out <= r_row_rd;
            default: ;
        endcase
        if (r_state == S_SCAN && r_k == LAST && !seg_hit) begin
            r_out <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_strobe <= n_strobe;
            unique case (r_state)
                S_IDLE: if (o_pop && i_cmd.is_eval) r_state <= S_CHK0;
                S_CHK0: r_state <= (r_angle <= bp_s) ? S_ROW : S_CHKL;
                S_CHKL: r_state <= (r_angle >= bp_s) ? S_ROW : S_SCAN;
                S_SCAN: begin
                    if (seg_hit) begin
                        r_state <= S_DIV;
                    end else if (r_k == LAST) begin
                        r_state <= S_IDLE;
                        r_valid <= 1'b0;
                    end
                end
                S_DIV:  if (r_den == '0 || r_dcnt == DIV_LAST) r_state <= S_RDA;
                S_RDA:  r_state <= S_RDB;
                S_RDB:  r_state <= S_RDC;
                S_RDC:  r_state <= S_MUL;
                S_MUL:  r_state <= S_ADD;
                S_ADD: begin
                    if (r_vi == VI_W'(NUM_VALS - 1)) begin
                        r_state <= S_IDLE;
                        r_valid <= 1'b1;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_ROW: begin
                    r_state <= S_IDLE;
                    r_valid <= 1'b1;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_strobe = r_strobe;
    assign o_valid  = r_valid;
    assign o_vals   = r_out;

    a_strobe_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |=> !r_strobe) else $error("result strobe held");
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && !r_valid) |-> (r_out == '0)) else $error("invalid result not zero");
    a_t_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_t <= T_W'(1 << FRAC_W))) else $error("fraction above one");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == S_IDLE)) else $error("pop while engine busy");

endmodule

@@ sim/gain_schedule_interpolator_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// gain_schedule_interpolator_tb
// Self-checking bench: table writes and angle lookups are driven through the
// start/busy handshake; every strobed result is checked against a local
// piecewise-linear predictor with Q16.16 saturation or, for directed rows, typed values.
// ============================================================================
module gain_schedule_interpolator_tb;
    import gsi_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int N_RANDOM     = 1700;
    localparam int DRAIN_CYCLES = 80;

    // one row of the directed table; chk set means exp_* is typed in
    typedef struct {
        logic        op;
        logic [3:0]  row;
        logic [31:0] angle;
        logic [31:0] bp;
        logic [31:0] v [6];
        logic        chk;
        logic        exp_ok;
        logic [31:0] exp_v [6];
    } t_dir_row;

    typedef struct {
        logic        ok;
        logic [31:0] v [6];
    } t_lookup;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_op = OP_WRITE;
    logic [3:0]  i_row_index = '0;
    logic [31:0] i_hip_angle = '0;
    logic [31:0] i_breakpoint_in = '0;
    logic [31:0] i_gain_in_0 = '0, i_gain_in_1 = '0, i_gain_in_2 = '0, i_gain_in_3 = '0;
    logic [31:0] i_eq_angle_in = '0, i_eq_drive_in = '0;
    logic        o_strobe, o_valid_out;
    logic [31:0] o_gain_out_0, o_gain_out_1, o_gain_out_2, o_gain_out_3;
    logic [31:0] o_eq_angle_out, o_eq_drive_out;

    gain_schedule_interpolator dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor copy of the schedule table
    logic signed [31:0] bp_tab [TABLE_ROWS];
    logic signed [31:0] val_tab [TABLE_ROWS][6];

    t_lookup pending_lookups [$];
    int      n_fail = 0;
    int      n_checked = 0;
    int      n_interp = 0;
    int      n_clamped = 0;
    longint  cyc = 0;

    function automatic logic [31:0] sat32(longint v);
        if (v > 64'sd2147483647) return 32'h7fff_ffff;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    // y0 + floor((y1 - y0) * t / 2^16), saturated
    function automatic logic [31:0] blend(logic signed [31:0] y0, logic signed [31:0] y1,
                                          longint t);
        longint d;
        longint q;
        d = longint'(y1) - longint'(y0);
        q = (d * t) >>> 16;
        return sat32(longint'(y0) + q);
    endfunction

    function automatic t_lookup predict_lookup(logic signed [31:0] a);
        t_lookup r;
        longint  x0, x1, t;
        r.ok = 1'b0;
        for (int k = 0; k < 6; k++) r.v[k] = '0;
        if (a <= bp_tab[0] || a >= bp_tab[TABLE_ROWS-1]) begin
            int row;
            row = (a <= bp_tab[0]) ? 0 : TABLE_ROWS - 1;
            r.ok = 1'b1;
            for (int k = 0; k < 6; k++) r.v[k] = val_tab[row][k];
            n_clamped++;
            return r;
        end
        for (int s = 0; s + 1 < TABLE_ROWS; s++) begin
            x0 = bp_tab[s];
            x1 = bp_tab[s+1];
            if (a >= x0 && a <= x1) begin
                t = (x1 > x0) ? ((longint'(a) - x0) <<< 16) / (x1 - x0) : 0;
                r.ok = 1'b1;
                for (int k = 0; k < 6; k++) r.v[k] = blend(val_tab[s][k], val_tab[s+1][k], t);
                n_interp++;
                return r;
            end
        end
        return r;
    endfunction

    // result checker: strobe sampled at the rising edge
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (i_rst_n && o_strobe) begin
            t_lookup e;
            logic [31:0] got [6];
            got = '{o_gain_out_0, o_gain_out_1, o_gain_out_2, o_gain_out_3,
                    o_eq_angle_out, o_eq_drive_out};
            if (pending_lookups.size() == 0) begin
                $display("%0t: unexpected result, valid_out=%0b", $time, o_valid_out);
                n_fail++;
            end else begin
                e = pending_lookups.pop_front();
                n_checked++;
                if (o_valid_out !== e.ok) begin
                    $display("%0t: valid_out expected %0b actual %0b", $time, e.ok, o_valid_out);
                    n_fail++;
                end
                for (int k = 0; k < 6; k++)
                    if (got[k] !== e.v[k]) begin
                        $display("%0t: value %0d expected %h actual %h", $time, k, e.v[k], got[k]);
                        n_fail++;
                    end
            end
        end
        if (cyc > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, pending_lookups.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // one transfer: present at the falling edge, hold until accepted
    task automatic send(logic op, logic [3:0] row, logic [31:0] angle, logic [31:0] bp,
                        logic [31:0] v [6], logic chk, t_lookup typed);
        t_lookup e;
        i_op <= op;
        i_row_index <= row;
        i_hip_angle <= angle;
        i_breakpoint_in <= bp;
        i_gain_in_0 <= v[0];
        i_gain_in_1 <= v[1];
        i_gain_in_2 <= v[2];
        i_gain_in_3 <= v[3];
        i_eq_angle_in <= v[4];
        i_eq_drive_in <= v[5];
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        // accepted at this edge: update predictor in transfer order
        if (op == OP_WRITE) begin
            bp_tab[row] = bp;
            for (int k = 0; k < 6; k++) val_tab[row][k] = v[k];
        end else begin
            e = predict_lookup(angle);
            if (chk) e = typed;
            pending_lookups.push_back(e);
        end
        @(negedge i_clk);
    endtask

    task automatic idle(int n);
        start <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rnd_word();
        case ($urandom_range(0, 5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
            3: return $urandom_range(0, 1 << 20) - (1 << 19);
            default: return $urandom();
        endcase
    endfunction

    // ascending breakpoints over a random span; duplicates give zero-width segments
    task automatic load_schedule(bit wide, bit tail);
        logic [31:0] v [6];
        longint      x;
        t_lookup     none;
        x = wide ? -64'sd2147483648 : -longint'($urandom_range(0, 1 << 20));
        for (int r = 0; r < TABLE_ROWS; r++) begin
            for (int k = 0; k < 6; k++) v[k] = rnd_word();
            if (r == TABLE_ROWS - 1 && wide) x = 64'sd2147483647;
            send(OP_WRITE, r[3:0], 32'h0, x[31:0], v, 1'b0, none);
            if (!tail && $urandom_range(0, 3) == 0) idle($urandom_range(1, 14));
            if ($urandom_range(0, 7) != 0)
                x += wide ? longint'($urandom_range(1, 32'h1000_0000))
                          : longint'($urandom_range(1, 1 << 17));
        end
    endtask

    function automatic logic [31:0] pick_angle();
        case ($urandom_range(0, 5))
            0: return bp_tab[$urandom_range(0, TABLE_ROWS - 1)];
            1: return bp_tab[$urandom_range(0, TABLE_ROWS - 1)] + $urandom_range(0, 3) - 1;
            2: return $urandom();
            default: begin
                longint lo, hi;
                lo = bp_tab[0];
                hi = bp_tab[TABLE_ROWS-1];
                return 32'(lo + ((hi - lo + 3) * longint'($urandom_range(0, 65535)) >> 16) - 1);
            end
        endcase
    endfunction

    t_dir_row dir_tab [$];

    initial begin
        t_dir_row    d;
        logic [31:0] v [6];
        t_lookup     typed;
        int          n_items;

        // directed table: full-scale values, clamping at both ends, exact
        // breakpoint hits, a zero-width segment and non-ascending breakpoints
        for (int r = 0; r < TABLE_ROWS; r++) begin
            d = '{default: '0};
            d.op = OP_WRITE;
            d.row = r[3:0];
            d.bp = (r == 0) ? 32'h8000_0000 : (r == TABLE_ROWS - 1) ? 32'h7fff_ffff
                 : (r == 8) ? 32'(7 << 16) : 32'(r << 16);
            for (int k = 0; k < 6; k++)
                d.v[k] = r[0] ? 32'h7fff_ffff : (k[0] ? 32'h8000_0000 : 32'h0);
            dir_tab.push_back(d);
        end
        // minimum angle returns row 0 as written
        d = '{default: '0};
        d.op = OP_EVAL;
        d.angle = 32'h8000_0000;
        d.chk = 1'b1;
        d.exp_ok = 1'b1;
        for (int k = 0; k < 6; k++) d.exp_v[k] = k[0] ? 32'h8000_0000 : 32'h0;
        dir_tab.push_back(d);
        // maximum angle returns the last row
        d.angle = 32'h7fff_ffff;
        for (int k = 0; k < 6; k++) d.exp_v[k] = 32'h7fff_ffff;
        dir_tab.push_back(d);
        d.chk = 1'b0;
        d.angle = 32'(7 << 16);        // exact hit on the duplicate breakpoint, taken by the segment below it
        dir_tab.push_back(d);
        d.angle = 32'h0003_8000;       // interpolated midpoint
        dir_tab.push_back(d);
        d.angle = 32'h000e_ffff;
        dir_tab.push_back(d);
        // break ascending order: an angle past the misplaced breakpoint still
        // lands on a later segment
        d = '{default: '0};
        d.op = OP_WRITE;
        d.row = 4'd5;
        d.bp = 32'h0100_0000;
        dir_tab.push_back(d);
        d = '{default: '0};
        d.op = OP_EVAL;
        d.angle = 32'h0200_0000;
        dir_tab.push_back(d);

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_tab[i]) begin
            typed.ok = dir_tab[i].exp_ok;
            typed.v = dir_tab[i].exp_v;
            send(dir_tab[i].op, dir_tab[i].row, dir_tab[i].angle, dir_tab[i].bp,
                 dir_tab[i].v, dir_tab[i].chk, typed);
            if ($urandom_range(0, 2) == 0) idle($urandom_range(1, 14));
        end

        // random phases: reload the schedule, then mostly lookups
        typed.ok = 1'b0;
        n_items = 0;
        while (n_items < N_RANDOM) begin
            bit tail;
            tail = (n_items > N_RANDOM - 200);
            load_schedule($urandom_range(0, 3) == 0, tail);
            n_items += TABLE_ROWS;
            // hold off until the engine has drained
            if (!tail) begin
                idle(1);
                while (pending_lookups.size() != 0) @(negedge i_clk);
            end
            for (int j = 0; j < 60; j++) begin
                bit quiet;
                quiet = (n_items > N_RANDOM - 200);
                if ($urandom_range(0, 15) == 0) begin
                    // stray row rewrite, ascending order may break
                    for (int k = 0; k < 6; k++) v[k] = rnd_word();
                    send(OP_WRITE, 4'($urandom_range(0, 15)), $urandom(), rnd_word(),
                         v, 1'b0, typed);
                end else begin
                    for (int k = 0; k < 6; k++) v[k] = $urandom();
                    send(OP_EVAL, 4'($urandom()), pick_angle(), $urandom(), v, 1'b0, typed);
                end
                n_items++;
                if (!quiet && $urandom_range(0, 3) == 0) idle($urandom_range(1, 14));
            end
        end
        start <= 1'b0;

        while (pending_lookups.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Checked %0d lookups (%0d clamped to an end row, %0d interpolated) over %0d items.",
                 n_checked, n_clamped, n_interp, n_items + dir_tab.size());
        if (n_fail == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", n_fail);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
